>>> rtl/core/sag_pkg.sv
// ----------------------------------------------------------------------------
// sag_pkg: shared types and constants
// Serial arithmetic requests, sequencer states and fixed constants for the
// spatial gain, pan and Doppler unit.
// ----------------------------------------------------------------------------
package sag_pkg;

	localparam int unsigned MAC_AW = 64;
	localparam int unsigned MAC_BW = 32;
	localparam int unsigned DIV_NW = 64;
	localparam int unsigned DIV_DW = 50;

	typedef struct packed {
		logic              start;
		logic              clr;
		logic              neg;
		logic [MAC_AW-1:0] a;
		logic [MAC_BW-1:0] b;
	} mac_req_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	localparam logic [2:0] REG_BASE_VOLUME    = 3'd0;
	localparam logic [2:0] REG_BASE_FREQUENCY = 3'd1;
	localparam logic [2:0] REG_NEAR_DIST_SQ   = 3'd2;
	localparam logic [2:0] REG_FAR_DIST_SQ    = 3'd3;
	localparam logic [2:0] REG_PROP_SPEED     = 3'd4;
	localparam logic [2:0] REG_APPROACH_LIMIT = 3'd5;

	localparam logic [15:0] RST_BASE_VOLUME    = 16'd16384;
	localparam logic [15:0] RST_BASE_FREQUENCY = 16'd4096;
	localparam logic [31:0] RST_NEAR_DIST_SQ   = 32'd2048;
	localparam logic [31:0] RST_FAR_DIST_SQ    = 32'd262144;
	localparam logic [22:0] RST_PROP_SPEED     = 23'd1404928;
	localparam logic [22:0] RST_APPROACH_LIMIT = 23'd702464;

	localparam logic [15:0] PAN_COEF     = 16'd11469;
	localparam logic [22:0] ORIGIN_SPEED = 23'd1404928;
	localparam logic [22:0] ORIGIN_LIMIT = 23'd702464;
	localparam logic [15:0] UNITY_FREQ   = 16'd4096;
	localparam logic [15:0] PAN_CAP_POS  = 16'd16384;
	localparam logic [15:0] PAN_CAP_NEG  = 16'd16383;
	localparam logic [15:0] FREQ_MAX     = 16'hFFFF;
	localparam logic [4:0]  SQRT_STEPS   = 5'd24;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_X, ST_SQ_Y, ST_SQ_Z,
		ST_VOL_SEL, ST_VOL_MUL, ST_VOL_DIV,
		ST_PAN_SEL, ST_DOT_X, ST_DOT_Y, ST_DOT_Z,
		ST_M_SQ, ST_PAN_MUL, ST_PAN_DIV,
		ST_SQRT, ST_VR_X, ST_VR_Y, ST_VR_Z, ST_Q_DIV,
		ST_FREQ_SEL, ST_FREQ_MUL, ST_FREQ_DIV,
		ST_GROUP, ST_WP_MUL, ST_WF_MUL, ST_CLOSE,
		ST_GP_DIV, ST_GF_DIV, ST_EMIT
	} state_t;

endpackage

>>> rtl/core/sag_mac.sv
// ----------------------------------------------------------------------------
// sag_mac: bit-serial multiply-accumulate
// Adds or subtracts a*b into the accumulator, one multiplier bit per cycle,
// finishing as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module sag_mac (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sag_pkg::mac_req_t              req,
	output logic                           busy,
	output logic [sag_pkg::MAC_AW-1:0]     acc
);

	logic                       busy_q;
	logic [sag_pkg::MAC_AW-1:0] a_q;
	logic [sag_pkg::MAC_BW-1:0] b_q;
	logic                       neg_q;
	logic [sag_pkg::MAC_AW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && (b_q == '0)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			neg_q <= req.neg;
			if (req.clr) begin
				acc_q <= '0;
			end
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= neg_q ? (acc_q - a_q) : (acc_q + a_q);
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign acc  = acc_q;

endmodule

>>> rtl/core/sag_div.sv
// ----------------------------------------------------------------------------
// sag_div: restoring divider
// Unsigned division producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sag_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sag_pkg::div_req_t          req,
	output logic                       busy,
	output logic [sag_pkg::DIV_NW-1:0] quo
);

	localparam int unsigned CW = $clog2(sag_pkg::DIV_NW + 1);
	localparam int unsigned NW = sag_pkg::DIV_NW;
	localparam int unsigned DW = sag_pkg::DIV_DW;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] n_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {r_q, n_q[NW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.num;
			r_q <= '0;
			d_q <= req.den;
		end else if (busy_q) begin
			r_q <= fits ? DW'(trial - {1'b0, d_q}) : trial[DW-1:0];
			n_q <= {n_q[NW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = n_q;

endmodule

>>> rtl/core/spatial_audio_gain_pan_doppler_unit.sv
// ----------------------------------------------------------------------------
// spatial_audio_gain_pan_doppler_unit: distance gain, pan and Doppler
// Per listener: squared distance, volume, pan and Doppler frequency scale;
// groups of listeners are merged into peak volume and weighted pan/frequency.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   contents
//  s_*       in         s_tvalid / s_tready         one listener per transfer
//  m_*       out        m_tvalid / m_tready         one result per group
//  cfg_*     in         cfg_valid / cfg_ready       register index and data
//
// A listener with all offsets zero skips the volume, pan and Doppler steps;
// otherwise its time is set by the shared bit-serial multiplier, the
// restoring divider (up to four divisions per listener, two more at a group
// end) and the 24-step square root. Reset clears the sequencer, the group
// sums and the held pan, and sets the held frequency to unity.
// The next listener is taken while a result still waits on m_tready.
// ----------------------------------------------------------------------------
module spatial_audio_gain_pan_doppler_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// rel_x, rel_y, rel_z, rvel_x, rvel_y, rvel_z, orient_x, orient_y, orient_z
	input  logic [191:0] s_tdata,
	// from_origin
	input  logic [0:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// spatial_volume, spatial_pan, spatial_frequency, zero pad
	output logic [47:0]  m_tdata,
	// any_audible
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	function automatic logic [23:0] mag24(input logic [23:0] v);
		mag24 = v[23] ? (~v + 24'd1) : v;
	endfunction

	function automatic logic [15:0] mag16(input logic [15:0] v);
		mag16 = v[15] ? (~v + 16'd1) : v;
	endfunction

	// configuration
	logic [15:0] base_vol_q, base_freq_q;
	logic [31:0] near_q, far_q;
	logic [22:0] speed_q, limit_q;

	// sequencer
	sag_pkg::state_t   state_q, state_d;
	logic              launch_q, launch_d;
	logic              mac_op, div_op, sqrt_op, unit_done;
	sag_pkg::mac_req_t mac_req;
	sag_pkg::div_req_t div_req;
	logic              mac_busy, div_busy;
	logic [63:0]       mac_acc, div_quo;
	logic [4:0]        sq_cnt_q;

	// listener
	logic signed [23:0] rx_q, ry_q, rz_q, vx_q, vy_q, vz_q;
	logic signed [15:0] ox_q, oy_q, oz_q;
	logic               origin_q, last_q;
	logic [47:0]        s_q;
	logic [15:0]        vol_q, freq_q;
	logic [15:0]        pan_q;
	logic [25:0]        m_q;
	logic               pos_q;
	logic [48:0]        sq_n_q, sq_r_q, sq_bit_q, sq_sum;
	logic [23:0]        d_q;
	logic               vr_neg_q;
	logic [47:0]        vr_mag_q, q_q;
	logic [49:0]        den_q;
	logic               aud_q;

	// group
	logic [23:0]        sum_vol_q;
	logic [39:0]        swp_q, swf_q;
	logic [15:0]        peak_q, held_pan_q, held_freq_q;
	logic               gaud_q, gopen_q;

	// output register
	logic               m_tvalid_q, aud_out_q;
	logic [15:0]        vol_out_q, freq_out_q;
	logic [14:0]        pan_out_q;
	logic               out_free;

	// combinational helpers
	logic [31:0] d2, far_minus_d2, span;
	logic [63:0] acc_mag;
	logic        acc_pos;
	logic [22:0] c_sel, lim_sel;
	logic signed [50:0] v_raw, v_clamp, den_s;
	logic [15:0] pan_mag, gp_q;
	logic [41:0] wp_sum;
	logic [40:0] wf_sum;
	logic [24:0] sv_sum;
	logic [39:0] swp_mag;

	assign d2           = s_q[47:16];
	assign far_minus_d2 = far_q - d2;
	assign span         = far_q - near_q;
	assign acc_mag      = mac_acc[63] ? (~mac_acc + 64'd1) : mac_acc;
	assign acc_pos      = !mac_acc[63] && (mac_acc != '0);
	assign c_sel        = origin_q ? sag_pkg::ORIGIN_SPEED : speed_q;
	assign lim_sel      = origin_q ? sag_pkg::ORIGIN_LIMIT : limit_q;
	assign v_raw        = vr_neg_q ? $signed({3'd0, q_q}) : -$signed({3'd0, q_q});
	assign v_clamp      = (v_raw > $signed({28'd0, lim_sel})) ?
	                      $signed({28'd0, lim_sel}) : v_raw;
	assign den_s        = $signed({28'd0, c_sel}) - v_clamp;
	assign sq_sum       = sq_r_q + sq_bit_q;
	assign wp_sum       = {{2{swp_q[39]}}, swp_q} + mac_acc[41:0];
	assign wf_sum       = {1'b0, swf_q} + {9'd0, mac_acc[31:0]};
	assign sv_sum       = {1'b0, sum_vol_q} + {9'd0, vol_q};
	assign swp_mag      = swp_q[39] ? (~swp_q + 40'd1) : swp_q;
	assign out_free     = !m_tvalid_q || m_tready;

	always_comb begin
		if (pos_q) begin
			pan_mag = (div_quo > 64'(sag_pkg::PAN_CAP_POS)) ? sag_pkg::PAN_CAP_POS
			                                                 : div_quo[15:0];
		end else begin
			pan_mag = (div_quo > 64'(sag_pkg::PAN_CAP_NEG)) ? sag_pkg::PAN_CAP_NEG
			                                                 : div_quo[15:0];
		end
		gp_q = (div_quo > 64'(sag_pkg::PAN_CAP_POS)) ? sag_pkg::PAN_CAP_POS
		                                              : div_quo[15:0];
	end

	sag_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.busy   (mac_busy),
		.acc    (mac_acc)
	);

	sag_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign unit_done = launch_q && !mac_busy && !div_busy && (sq_cnt_q == '0);

	// Sequencer: each arithmetic state launches its unit once, then waits.
	always_comb begin
		state_d = state_q;
		mac_op  = 1'b0;
		div_op  = 1'b0;
		sqrt_op = 1'b0;
		mac_req = '0;
		div_req = '0;
		unique case (state_q)
			sag_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = sag_pkg::ST_SQ_X;
			end
			sag_pkg::ST_SQ_X: begin
				mac_op = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.a = {40'd0, mag24(rx_q)};
				mac_req.b = {8'd0, mag24(rx_q)};
				if (unit_done) state_d = sag_pkg::ST_SQ_Y;
			end
			sag_pkg::ST_SQ_Y: begin
				mac_op = 1'b1;
				mac_req.a = {40'd0, mag24(ry_q)};
				mac_req.b = {8'd0, mag24(ry_q)};
				if (unit_done) state_d = sag_pkg::ST_SQ_Z;
			end
			sag_pkg::ST_SQ_Z: begin
				mac_op = 1'b1;
				mac_req.a = {40'd0, mag24(rz_q)};
				mac_req.b = {8'd0, mag24(rz_q)};
				if (unit_done) state_d = sag_pkg::ST_VOL_SEL;
			end
			sag_pkg::ST_VOL_SEL: begin
				if (d2 <= near_q || d2 >= far_q) state_d = sag_pkg::ST_PAN_SEL;
				else state_d = sag_pkg::ST_VOL_MUL;
			end
			sag_pkg::ST_VOL_MUL: begin
				mac_op = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.a = {32'd0, origin_q ? near_q : far_minus_d2};
				mac_req.b = {16'd0, base_vol_q};
				if (unit_done) state_d = sag_pkg::ST_VOL_DIV;
			end
			sag_pkg::ST_VOL_DIV: begin
				div_op = 1'b1;
				div_req.num = mac_acc;
				div_req.den = {18'd0, origin_q ? d2 : span};
				if (unit_done) state_d = sag_pkg::ST_PAN_SEL;
			end
			sag_pkg::ST_PAN_SEL: begin
				priority if (vol_q == '0 || s_q == '0) state_d = sag_pkg::ST_GROUP;
				else if (origin_q) state_d = sag_pkg::ST_M_SQ;
				else state_d = sag_pkg::ST_DOT_X;
			end
			sag_pkg::ST_DOT_X: begin
				mac_op = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.neg = rx_q[23] ^ ox_q[15];
				mac_req.a = {40'd0, mag24(rx_q)};
				mac_req.b = {16'd0, mag16(ox_q)};
				if (unit_done) state_d = sag_pkg::ST_DOT_Y;
			end
			sag_pkg::ST_DOT_Y: begin
				mac_op = 1'b1;
				mac_req.neg = ry_q[23] ^ oy_q[15];
				mac_req.a = {40'd0, mag24(ry_q)};
				mac_req.b = {16'd0, mag16(oy_q)};
				if (unit_done) state_d = sag_pkg::ST_DOT_Z;
			end
			sag_pkg::ST_DOT_Z: begin
				mac_op = 1'b1;
				mac_req.neg = rz_q[23] ^ oz_q[15];
				mac_req.a = {40'd0, mag24(rz_q)};
				mac_req.b = {16'd0, mag16(oz_q)};
				if (unit_done) state_d = sag_pkg::ST_M_SQ;
			end
			sag_pkg::ST_M_SQ: begin
				mac_op = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.a = {38'd0, m_q};
				mac_req.b = {6'd0, m_q};
				if (unit_done) begin
					// A pan ratio of two or more saturates without dividing.
					if (mac_acc[51:0] >= {3'd0, s_q, 1'b0}) state_d = sag_pkg::ST_SQRT;
					else state_d = sag_pkg::ST_PAN_MUL;
				end
			end
			sag_pkg::ST_PAN_MUL: begin
				mac_op = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.a = mac_acc;
				mac_req.b = {16'd0, sag_pkg::PAN_COEF};
				if (unit_done) state_d = sag_pkg::ST_PAN_DIV;
			end
			sag_pkg::ST_PAN_DIV: begin
				div_op = 1'b1;
				div_req.num = mac_acc;
				div_req.den = {2'd0, s_q};
				if (unit_done) state_d = sag_pkg::ST_SQRT;
			end
			sag_pkg::ST_SQRT: begin
				sqrt_op = 1'b1;
				if (unit_done) state_d = sag_pkg::ST_VR_X;
			end
			sag_pkg::ST_VR_X: begin
				mac_op = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.neg = rx_q[23] ^ vx_q[23];
				mac_req.a = {40'd0, mag24(rx_q)};
				mac_req.b = {8'd0, mag24(vx_q)};
				if (unit_done) state_d = sag_pkg::ST_VR_Y;
			end
			sag_pkg::ST_VR_Y: begin
				mac_op = 1'b1;
				mac_req.neg = ry_q[23] ^ vy_q[23];
				mac_req.a = {40'd0, mag24(ry_q)};
				mac_req.b = {8'd0, mag24(vy_q)};
				if (unit_done) state_d = sag_pkg::ST_VR_Z;
			end
			sag_pkg::ST_VR_Z: begin
				mac_op = 1'b1;
				mac_req.neg = rz_q[23] ^ vz_q[23];
				mac_req.a = {40'd0, mag24(rz_q)};
				mac_req.b = {8'd0, mag24(vz_q)};
				if (unit_done) state_d = sag_pkg::ST_Q_DIV;
			end
			sag_pkg::ST_Q_DIV: begin
				div_op = 1'b1;
				div_req.num = {16'd0, vr_mag_q};
				div_req.den = {26'd0, d_q};
				if (unit_done) state_d = sag_pkg::ST_FREQ_SEL;
			end
			sag_pkg::ST_FREQ_SEL: begin
				if (den_s <= 0) state_d = sag_pkg::ST_GROUP;
				else state_d = sag_pkg::ST_FREQ_MUL;
			end
			sag_pkg::ST_FREQ_MUL: begin
				mac_op = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.a = {41'd0, c_sel};
				mac_req.b = {16'd0, base_freq_q};
				if (unit_done) state_d = sag_pkg::ST_FREQ_DIV;
			end
			sag_pkg::ST_FREQ_DIV: begin
				div_op = 1'b1;
				div_req.num = mac_acc;
				div_req.den = den_q;
				if (unit_done) state_d = sag_pkg::ST_GROUP;
			end
			sag_pkg::ST_GROUP: begin
				priority if (!gopen_q && last_q) state_d = sag_pkg::ST_EMIT;
				else if (vol_q != '0) state_d = sag_pkg::ST_WP_MUL;
				else state_d = sag_pkg::ST_CLOSE;
			end
			sag_pkg::ST_WP_MUL: begin
				mac_op = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.neg = pan_q[15];
				mac_req.a = {48'd0, mag16(pan_q)};
				mac_req.b = {16'd0, vol_q};
				if (unit_done) state_d = sag_pkg::ST_WF_MUL;
			end
			sag_pkg::ST_WF_MUL: begin
				mac_op = 1'b1;
				mac_req.clr = 1'b1;
				mac_req.a = {48'd0, freq_q};
				mac_req.b = {16'd0, vol_q};
				if (unit_done) state_d = sag_pkg::ST_CLOSE;
			end
			sag_pkg::ST_CLOSE: begin
				priority if (!last_q) state_d = sag_pkg::ST_IDLE;
				else if (gaud_q && sum_vol_q != '0) state_d = sag_pkg::ST_GP_DIV;
				else state_d = sag_pkg::ST_EMIT;
			end
			sag_pkg::ST_GP_DIV: begin
				div_op = 1'b1;
				div_req.num = {24'd0, swp_mag};
				div_req.den = {26'd0, sum_vol_q};
				if (unit_done) state_d = sag_pkg::ST_GF_DIV;
			end
			sag_pkg::ST_GF_DIV: begin
				div_op = 1'b1;
				div_req.num = {24'd0, swf_q};
				div_req.den = {26'd0, sum_vol_q};
				if (unit_done) state_d = sag_pkg::ST_EMIT;
			end
			sag_pkg::ST_EMIT: begin
				if (out_free) state_d = sag_pkg::ST_IDLE;
			end
			default: state_d = sag_pkg::ST_IDLE;
		endcase
		mac_req.start = mac_op && !launch_q;
		div_req.start = div_op && !launch_q;
		if (mac_op || div_op || sqrt_op) launch_d = launch_q ? !unit_done : 1'b1;
		else launch_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sag_pkg::ST_IDLE;
			launch_q <= 1'b0;
			sq_cnt_q <= '0;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
			if (sqrt_op && !launch_q) sq_cnt_q <= sag_pkg::SQRT_STEPS;
			else if (sq_cnt_q != '0) sq_cnt_q <= sq_cnt_q - 1'b1;
		end
	end

	// Per-listener datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			sag_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					rx_q     <= s_tdata[23:0];
					ry_q     <= s_tdata[47:24];
					rz_q     <= s_tdata[71:48];
					vx_q     <= s_tdata[95:72];
					vy_q     <= s_tdata[119:96];
					vz_q     <= s_tdata[143:120];
					ox_q     <= s_tdata[159:144];
					oy_q     <= s_tdata[175:160];
					oz_q     <= s_tdata[191:176];
					origin_q <= s_tuser[0];
					last_q   <= s_tlast;
				end
			end
			sag_pkg::ST_SQ_Z: begin
				if (unit_done) s_q <= mac_acc[47:0];
			end
			sag_pkg::ST_VOL_SEL: begin
				if (d2 <= near_q) vol_q <= base_vol_q;
				else if (d2 >= far_q) vol_q <= '0;
			end
			sag_pkg::ST_VOL_DIV: begin
				if (unit_done) vol_q <= div_quo[15:0];
			end
			sag_pkg::ST_PAN_SEL: begin
				if (vol_q == '0) begin
					pan_q  <= held_pan_q;
					freq_q <= held_freq_q;
				end else if (s_q == '0) begin
					// Source on top of the listener: centered, no shift.
					pan_q  <= '0;
					freq_q <= base_freq_q;
				end else begin
					m_q   <= {2'd0, mag24(ry_q)};
					pos_q <= !ry_q[23] && (ry_q != '0);
				end
			end
			sag_pkg::ST_DOT_Z: begin
				if (unit_done) begin
					m_q   <= acc_mag[39:14];
					pos_q <= acc_pos;
				end
			end
			sag_pkg::ST_M_SQ: begin
				if (unit_done) begin
					pan_q <= pos_q ? (~sag_pkg::PAN_CAP_POS + 16'd1) : sag_pkg::PAN_CAP_NEG;
				end
			end
			sag_pkg::ST_PAN_DIV: begin
				if (unit_done) pan_q <= pos_q ? (~pan_mag + 16'd1) : pan_mag;
			end
			sag_pkg::ST_SQRT: begin
				if (!launch_q) begin
					sq_n_q   <= {1'b0, s_q};
					sq_r_q   <= '0;
					sq_bit_q <= 49'd1 << 46;
				end else if (sq_cnt_q != '0) begin
					if (sq_n_q >= sq_sum) begin
						sq_n_q <= sq_n_q - sq_sum;
						sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
				end else begin
					d_q <= sq_r_q[23:0];
				end
			end
			sag_pkg::ST_VR_Z: begin
				if (unit_done) begin
					vr_neg_q <= mac_acc[63];
					vr_mag_q <= acc_mag[47:0];
				end
			end
			sag_pkg::ST_Q_DIV: begin
				if (unit_done) q_q <= div_quo[47:0];
			end
			sag_pkg::ST_FREQ_SEL: begin
				den_q <= den_s[49:0];
				if (den_s <= 0) freq_q <= sag_pkg::FREQ_MAX;
			end
			sag_pkg::ST_FREQ_DIV: begin
				if (unit_done) begin
					freq_q <= (div_quo > 64'(sag_pkg::FREQ_MAX)) ? sag_pkg::FREQ_MAX
					                                              : div_quo[15:0];
				end
			end
			sag_pkg::ST_GROUP: begin
				aud_q <= (vol_q != '0);
			end
			sag_pkg::ST_CLOSE: begin
				if (!(gaud_q && sum_vol_q != '0)) begin
					vol_q  <= '0;
					pan_q  <= '0;
					freq_q <= sag_pkg::UNITY_FREQ;
					aud_q  <= 1'b0;
				end
			end
			sag_pkg::ST_GP_DIV: begin
				if (unit_done) begin
					if (swp_q[39]) pan_q <= ~gp_q + 16'd1;
					else pan_q <= (gp_q > sag_pkg::PAN_CAP_NEG) ? sag_pkg::PAN_CAP_NEG : gp_q;
				end
			end
			sag_pkg::ST_GF_DIV: begin
				if (unit_done) begin
					vol_q  <= peak_q;
					aud_q  <= 1'b1;
					freq_q <= (div_quo > 64'(sag_pkg::FREQ_MAX)) ? sag_pkg::FREQ_MAX
					                                              : div_quo[15:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Group accumulation and held values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vol_q   <= '0;
			swp_q       <= '0;
			swf_q       <= '0;
			peak_q      <= '0;
			gaud_q      <= 1'b0;
			gopen_q     <= 1'b0;
			held_pan_q  <= '0;
			held_freq_q <= sag_pkg::UNITY_FREQ;
		end else begin
			case (state_q)
				sag_pkg::ST_GROUP: begin
					if (vol_q != '0) begin
						held_pan_q  <= pan_q;
						held_freq_q <= freq_q;
						if (gopen_q || !last_q) begin
							gaud_q    <= 1'b1;
							sum_vol_q <= sv_sum[24] ? '1 : sv_sum[23:0];
							if (vol_q > peak_q) peak_q <= vol_q;
						end
					end
				end
				sag_pkg::ST_WP_MUL: begin
					if (unit_done) begin
						if (wp_sum[41:39] == 3'b000 || wp_sum[41:39] == 3'b111) begin
							swp_q <= wp_sum[39:0];
						end else begin
							swp_q <= wp_sum[41] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
						end
					end
				end
				sag_pkg::ST_WF_MUL: begin
					if (unit_done) swf_q <= wf_sum[40] ? '1 : wf_sum[39:0];
				end
				sag_pkg::ST_CLOSE: begin
					if (!last_q) begin
						gopen_q <= 1'b1;
					end else if (!(gaud_q && sum_vol_q != '0)) begin
						held_pan_q  <= '0;
						held_freq_q <= sag_pkg::UNITY_FREQ;
						sum_vol_q   <= '0;
						swp_q       <= '0;
						swf_q       <= '0;
						peak_q      <= '0;
						gaud_q      <= 1'b0;
						gopen_q     <= 1'b0;
					end
				end
				sag_pkg::ST_GF_DIV: begin
					if (unit_done) begin
						held_pan_q  <= pan_q;
						held_freq_q <= (div_quo > 64'(sag_pkg::FREQ_MAX)) ? sag_pkg::FREQ_MAX
						                                                   : div_quo[15:0];
						sum_vol_q   <= '0;
						swp_q       <= '0;
						swf_q       <= '0;
						peak_q      <= '0;
						gaud_q      <= 1'b0;
						gopen_q     <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_vol_q  <= sag_pkg::RST_BASE_VOLUME;
			base_freq_q <= sag_pkg::RST_BASE_FREQUENCY;
			near_q      <= sag_pkg::RST_NEAR_DIST_SQ;
			far_q       <= sag_pkg::RST_FAR_DIST_SQ;
			speed_q     <= sag_pkg::RST_PROP_SPEED;
			limit_q     <= sag_pkg::RST_APPROACH_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				sag_pkg::REG_BASE_VOLUME:    base_vol_q  <= cfg_data[15:0];
				sag_pkg::REG_BASE_FREQUENCY: base_freq_q <= cfg_data[15:0];
				sag_pkg::REG_NEAR_DIST_SQ:   near_q      <= cfg_data;
				sag_pkg::REG_FAR_DIST_SQ:    far_q       <= cfg_data;
				sag_pkg::REG_PROP_SPEED:     speed_q     <= cfg_data[22:0];
				sag_pkg::REG_APPROACH_LIMIT: limit_q     <= cfg_data[22:0];
				default: begin
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == sag_pkg::ST_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sag_pkg::ST_EMIT && out_free) begin
			vol_out_q  <= vol_q;
			pan_out_q  <= pan_q[14:0];
			freq_out_q <= freq_q;
			aud_out_q  <= aud_q;
		end
	end

	assign s_tready  = (state_q == sag_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {1'b0, freq_out_q, pan_out_q, vol_out_q};
	assign m_tuser   = aud_out_q;

endmodule
